>>> hdl/bfsp_pkg.sv
// shared types, widths and codes of the bellman-ford shortest path block
package bfsp_pkg;

    // fixed field widths
    localparam int VID_W       = 4;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_W      = 32;
    localparam int SRC_W       = 4;
    localparam int VCOUNT_W    = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    // defaults for the top level parameters
    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_MAX_EDGES    = 64;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'b1;

    localparam logic [SRC_W-1:0]    SOURCE_RESET = '0;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

    typedef struct packed {
        logic [VID_W-1:0]              edge_start;
        logic [VID_W-1:0]              edge_end;
        logic signed [WEIGHT_BITS-1:0] edge_cost;
        logic                          edge_last;
    } t_edge_item;

    typedef struct packed {
        logic [VID_W-1:0]         vertex_index;
        logic signed [DIST_W-1:0] path_distance;
        logic                     reached;
        logic                     result_last;
    } t_result_item;

    // front to queue
    typedef struct packed {
        logic       push;
        t_edge_item data;
    } t_q_push;

    // queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        t_edge_item data;
    } t_q_head;

endpackage

>>> hdl/bfsp_front.sv
// front end: takes edge transactions and stages them toward the queue
module bfsp_front
    import bfsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_edge_item i_item,
    input  logic       i_q_full,
    output logic       o_busy,
    output t_q_push    o_push
);

    logic       r_stage_valid;
    t_edge_item r_stage;
    logic       accept;
    logic       push;

    // stage can refill in the same cycle it drains
    assign o_busy = r_stage_valid && i_q_full;
    assign accept = i_start && !o_busy;
    assign push   = r_stage_valid && !i_q_full;

    assign o_push.push = push;
    assign o_push.data = r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else begin
            r_stage_valid <= accept || (r_stage_valid && !push);
            if (accept) begin
                r_stage <= i_item;
            end
        end
    end

endmodule

>>> hdl/bfsp_queue.sv
// short edge queue between front and back end
module bfsp_queue
    import bfsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    input  logic    i_pop,
    output logic    o_full,
    output t_q_head o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_edge_item       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];

    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return PTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr_ptr] <= i_push.data;
                r_wr_ptr        <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

endmodule

>>> hdl/bfsp_back.sv
// back end: edge store, relaxation pipeline and result readout
module bfsp_back
    import bfsp_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_q_head             i_head,
    output logic                o_pop,
    input  logic [SRC_W-1:0]    i_source_vertex,
    input  logic [VCOUNT_W-1:0] i_vertex_count,
    output logic                o_result_valid,
    output t_result_item        o_result
);

    localparam int VC_W = $clog2(MAX_VERTICES + 1);
    localparam int VI_W = $clog2(MAX_VERTICES);
    localparam int ET_W = $clog2(MAX_EDGES + 1);
    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef struct packed {
        logic [VID_W-1:0]              from_v;
        logic [VID_W-1:0]              to_v;
        logic signed [WEIGHT_BITS-1:0] weight;
    } t_stored_edge;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_RUN,
        S_DRAIN,
        S_OUT
    } t_state;

    t_stored_edge             mem_edge [MAX_EDGES];
    logic signed [DIST_W-1:0] mem_dist [MAX_VERTICES];

    t_state                   r_state;
    logic [ET_W-1:0]          r_total;
    logic [ET_W-1:0]          r_eidx;
    logic [VC_W-1:0]          r_pass;
    logic [VC_W-1:0]          r_n;
    logic [VC_W-1:0]          r_vidx;
    logic [MAX_VERTICES-1:0]  r_reached;

    // pipeline: issue, dist read, relax
    t_stored_edge             r_edge_q;
    logic                     r_d_valid;
    logic                     r_x_valid;
    logic                     r_x_ok;
    logic [VI_W-1:0]          r_x_a;
    logic [VI_W-1:0]          r_x_b;
    logic signed [WEIGHT_BITS-1:0] r_x_w;
    logic signed [DIST_W-1:0] r_da;
    logic signed [DIST_W-1:0] r_db;
    logic                     r_fwd_valid;
    logic [VI_W-1:0]          r_fwd_addr;
    logic signed [DIST_W-1:0] r_fwd_val;

    // readout
    logic                     r_rd_valid;
    logic [VC_W-1:0]          r_rd_idx;
    logic                     r_rd_last;
    logic                     r_out_valid;
    t_result_item             r_out;

    logic [VC_W-1:0]          live_n;
    logic                     src_ok;
    logic                     store_room;
    logic                     d_in_range;
    logic signed [DIST_W-1:0] da;
    logic signed [DIST_W-1:0] db;
    logic signed [DIST_W:0]   sum_wide;
    logic signed [DIST_W-1:0] sum;
    logic                     relax;
    logic [VI_W-1:0]          rd_addr_a;
    logic [VI_W-1:0]          rd_addr_b;
    logic                     dw_en;
    logic [VI_W-1:0]          dw_addr;
    logic signed [DIST_W-1:0] dw_data;

    assign o_pop          = (r_state == S_IDLE) && i_head.valid;
    assign store_room     = (r_total < ET_W'(MAX_EDGES));
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // count in force for this solve
    always_comb begin
        if (i_vertex_count == '0) begin
            live_n = VC_W'(1);
        end else if (int'(i_vertex_count) > MAX_VERTICES) begin
            live_n = VC_W'(MAX_VERTICES);
        end else begin
            live_n = VC_W'(i_vertex_count);
        end
    end
    assign src_ok = (int'(i_source_vertex) < int'(live_n));

    assign d_in_range = (int'(r_edge_q.from_v) < int'(r_n))
                     && (int'(r_edge_q.to_v) < int'(r_n));

    // forward the write of the previous edge, the memory read missed it
    always_comb begin
        da = (r_fwd_valid && (r_fwd_addr == r_x_a)) ? r_fwd_val : r_da;
        db = (r_fwd_valid && (r_fwd_addr == r_x_b)) ? r_fwd_val : r_db;
        sum_wide = (DIST_W+1)'(da) + (DIST_W+1)'(r_x_w);
        if (sum_wide[DIST_W] != sum_wide[DIST_W-1]) begin
            sum = sum_wide[DIST_W] ? DIST_MIN : DIST_MAX;
        end else begin
            sum = sum_wide[DIST_W-1:0];
        end
        relax = r_x_valid && r_x_ok && r_reached[r_x_a]
             && (!r_reached[r_x_b] || (sum < db));
    end

    assign rd_addr_a = (r_state == S_OUT) ? r_vidx[VI_W-1:0] : VI_W'(r_edge_q.from_v);
    assign rd_addr_b = VI_W'(r_edge_q.to_v);

    always_comb begin
        dw_en   = 1'b0;
        dw_addr = r_x_b;
        dw_data = sum;
        if ((r_state == S_INIT) && src_ok) begin
            dw_en   = 1'b1;
            dw_addr = VI_W'(i_source_vertex);
            dw_data = '0;
        end else if (relax) begin
            dw_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && store_room) begin
            mem_edge[r_total[EA_W-1:0]] <= '{from_v: i_head.data.edge_start,
                                            to_v:   i_head.data.edge_end,
                                            weight: i_head.data.edge_cost};
        end
        r_edge_q <= mem_edge[r_eidx[EA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (dw_en) begin
            mem_dist[dw_addr] <= dw_data;
        end
        r_da <= mem_dist[rd_addr_a];
        r_db <= mem_dist[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_eidx      <= '0;
            r_pass      <= '0;
            r_n         <= VC_W'(1);
            r_vidx      <= '0;
            r_reached   <= '0;
            r_d_valid   <= 1'b0;
            r_x_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_d_valid   <= (r_state == S_RUN);
            r_x_valid   <= r_d_valid;
            r_x_ok      <= d_in_range;
            r_x_a       <= VI_W'(r_edge_q.from_v);
            r_x_b       <= VI_W'(r_edge_q.to_v);
            r_x_w       <= r_edge_q.weight;
            r_fwd_valid <= relax;
            r_fwd_addr  <= r_x_b;
            r_fwd_val   <= sum;
            // init marks only the source, later relaxations add their end vertex
            if (r_state == S_INIT) begin
                r_reached <= src_ok ? (MAX_VERTICES'(1) << i_source_vertex) : '0;
            end else if (relax) begin
                r_reached[r_x_b] <= 1'b1;
            end

            r_rd_valid  <= (r_state == S_OUT) && (r_vidx != r_n);
            r_out_valid <= r_rd_valid;
            if (r_rd_valid) begin
                r_out.vertex_index  <= VID_W'(r_rd_idx);
                r_out.reached       <= r_reached[r_rd_idx[VI_W-1:0]];
                r_out.path_distance <= r_reached[r_rd_idx[VI_W-1:0]] ? r_da : '0;
                r_out.result_last   <= r_rd_last;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        if (store_room) begin
                            r_total <= ET_W'(r_total + 1'b1);
                        end
                        if (i_head.data.edge_last) begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_n       <= live_n;
                    r_eidx    <= '0;
                    r_pass    <= '0;
                    r_vidx    <= '0;
                    r_state <= (r_total == '0) ? S_OUT : S_RUN;
                end
                S_RUN: begin
                    if (ET_W'(r_eidx + 1'b1) == r_total) begin
                        r_eidx <= '0;
                        r_pass <= VC_W'(r_pass + 1'b1);
                        if (VC_W'(r_pass + 1'b1) == r_n) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_eidx <= ET_W'(r_eidx + 1'b1);
                    end
                end
                S_DRAIN: begin
                    if (!r_d_valid && !r_x_valid) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_vidx != r_n) begin
                        r_rd_idx   <= r_vidx;
                        r_rd_last  <= (VC_W'(r_vidx + 1'b1) == r_n);
                        r_vidx     <= VC_W'(r_vidx + 1'b1);
                    end
                    if (r_rd_valid && r_rd_last) begin
                        r_state <= S_IDLE;
                        r_total <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/bellman_ford_shortest_paths.sv
// top level of the bellman-ford single source shortest path block
//
// usage
// - edges come in as transactions on i_edge, taken at a clock edge with start
//   high and busy low; busy rises only when the front stage and the queue
//   behind it are both full
// - edges are stored in arrival order; the edge marked edge_last starts the
//   solve, edges beyond the store depth are dropped
// - the solve relaxes one stored edge per clock, making n passes over the E
//   stored edges for n vertices through the single relaxation pipeline on
//   the distance memory, then reads the results out
// - results leave one per clock on o_result with o_result_valid high for one
//   cycle each, vertex 0 first, result_last on vertex n - 1; the receiver
//   cannot stall, so the run goes out back to back
// - edges of the next graph may be sent during a solve; they wait in the
//   queue, and busy holds them off once it fills
// - the user must write source_vertex and vertex_count on the plain write port
//   only while the block is idle; the block itself does not enforce this
// - synchronous reset clears the edge count, reached flags and all control;
//   no memory clearing pass is needed
module bellman_ford_shortest_paths
    import bfsp_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_edge_item            i_edge,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_result_valid,
    output t_result_item          o_result
);

    // configuration registers
    logic [SRC_W-1:0]    r_source_vertex;
    logic [VCOUNT_W-1:0] r_vertex_count;

    // front to queue to back
    t_q_push q_push;
    t_q_head q_head;
    logic    q_full;
    logic    q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_vertex <= SOURCE_RESET;
            r_vertex_count  <= VCOUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SOURCE_VERTEX: r_source_vertex <= i_cfg_data[SRC_W-1:0];
                CFG_VERTEX_COUNT:  r_vertex_count  <= i_cfg_data[VCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end: stage accepted edge transactions
    bfsp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_edge),
        .i_q_full (q_full),
        .o_busy   (busy),
        .o_push   (q_push)
    );

    // decoupling queue, lets the front keep taking edges during a solve
    bfsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    // back end: store, relax, read out
    bfsp_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .i_source_vertex (r_source_vertex),
        .i_vertex_count  (r_vertex_count),
        .o_result_valid  (o_result_valid),
        .o_result        (o_result)
    );

endmodule

>>> hdl/bfsp_checker.sv
// port level checks of the shortest path block and their bind
module bfsp_checker
    import bfsp_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_result_valid,
    input t_result_item o_result
);

    // reset clears the result strobe
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe after reset");

    // a result run goes out without gaps
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.result_last) |=> o_result_valid)
        else $error("gap inside result run");

    // vertices come in ascending order
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.result_last)
        |=> (o_result.vertex_index == $past(o_result.vertex_index) + 4'd1))
        else $error("vertex index out of order");

    // unreached vertex reports zero distance
    a_unreached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.reached) |-> (o_result.path_distance == '0))
        else $error("unreached vertex with nonzero distance");

endmodule

bind bellman_ford_shortest_paths bfsp_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
